// ===== rtl/ame_pkg.sv =====
// Shared types, constants and codes for the adjacency matrix editor.
`timescale 1ns / 1ps
`default_nettype none

package ame_pkg;

    // Matrix geometry
    localparam int MAX_VERTICES = 32;
    localparam int ROW_AW       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int CMP_W        = 8;
    localparam int OUT_W        = 32;
    localparam int FIELD_W      = 6;
    localparam int OP_W         = 3;
    localparam int ST_W         = 3;

    typedef logic [MAX_VERTICES-1:0] t_row;
    typedef logic [ROW_AW-1:0]       t_idx;
    typedef logic [CNT_W-1:0]        t_cnt;
    typedef logic [CMP_W-1:0]        t_cmp;
    typedef logic [OUT_W-1:0]        t_out;

    localparam t_idx IDX_ONE = t_idx'(1);
    localparam t_cmp CMP_ONE = t_cmp'(1);
    localparam t_cmp CMP_MAX = t_cmp'(MAX_VERTICES);
    localparam t_cnt CNT_ONE = t_cnt'(1);

    // Request opcodes
    localparam logic [OP_W-1:0] OP_INSERT_VTX = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD_ARC    = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE_VTX = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE_ARC = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_ROW   = 3'd4;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_PRESENT   = 3'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [ST_W-1:0] ST_RANGE     = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd4;

    // Row operations of the shared column unit
    typedef enum logic [2:0] {
        COL_PASS  = 3'd0,
        COL_OPEN  = 3'd1,
        COL_CLOSE = 3'd2,
        COL_SET   = 3'd3,
        COL_CLEAR = 3'd4
    } t_col_op;

    typedef struct packed {
        t_col_op op;
        t_idx    col;
    } t_col_ctl;

endpackage

`default_nettype wire

// ===== rtl/ame_col_unit.sv =====
// Shared row unit: passes a row, opens or closes a column, sets or clears one bit.
`timescale 1ns / 1ps
`default_nettype none

module ame_col_unit (
    input  wire ame_pkg::t_row     i_row,
    input  wire ame_pkg::t_col_ctl i_ctl,
    output ame_pkg::t_row          o_row
);

    ame_pkg::t_row bit_m;
    ame_pkg::t_row low_m;

    // Masks for the addressed column and everything below it
    always_comb begin
        bit_m = ame_pkg::t_row'(1) << i_ctl.col;
        low_m = bit_m - ame_pkg::t_row'(1);
    end

    always_comb begin
        unique case (i_ctl.op)
            ame_pkg::COL_PASS:  o_row = i_row;
            // empty column at col, higher columns move up
            ame_pkg::COL_OPEN:  o_row = (i_row & low_m) | ((i_row & ~low_m) << 1);
            // drop column col, higher columns move down
            ame_pkg::COL_CLOSE: o_row = (i_row & low_m) | ((i_row >> 1) & ~low_m);
            ame_pkg::COL_SET:   o_row = i_row | bit_m;
            ame_pkg::COL_CLEAR: o_row = i_row & ~bit_m;
            default:            o_row = i_row;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/adjacency_matrix_editor.sv =====
// Top level: directed graph adjacency matrix with row memory and sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Directed graph kept as a square bit matrix of arcs plus a vertex count.
// A request is taken at a clock edge with start high and busy low; its
// fields are i_opcode, i_vertex_number, i_source_vertex and i_dest_vertex.
// Each request gives exactly one result on o_status, o_row_bits and
// o_vertex_count_out, shown for one cycle with o_done high. The receiver
// cannot hold results off, so none is ever stalled.
// Rejected or undefined requests are answered without leaving idle, so
// busy stays low. Read row, add arc and delete arc take one row memory read.
// Insert and delete walk every used row once through a single memory read
// port and the shared column unit, one row per cycle, writing each row in
// the cycle after its read; that walk sets the rate.
// A new request may start in the cycle o_done is shown.
// Synchronous reset empties the graph; data read from unused rows is never
// kept, so the memory needs no clearing pass and the block is ready right
// after reset.
module adjacency_matrix_editor (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               start,
    output logic                              busy,
    input  wire  [ame_pkg::OP_W-1:0]          i_opcode,
    input  wire  [ame_pkg::FIELD_W-1:0]       i_vertex_number,
    input  wire  [ame_pkg::FIELD_W-1:0]       i_source_vertex,
    input  wire  [ame_pkg::FIELD_W-1:0]       i_dest_vertex,
    output logic                              o_done,
    output logic [ame_pkg::ST_W-1:0]          o_status,
    output logic [ame_pkg::OUT_W-1:0]         o_row_bits,
    output logic [ame_pkg::FIELD_W-1:0]       o_vertex_count_out
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ROW   = 4'b0010,
        S_SHIFT = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    t_state                  r_state, n_state;
    logic [ame_pkg::OP_W-1:0] r_op, n_op;
    ame_pkg::t_idx           r_p, n_p;
    ame_pkg::t_idx           r_sv_idx, n_sv_idx;
    ame_pkg::t_idx           r_dv_idx, n_dv_idx;
    ame_pkg::t_idx           r_last_idx, n_last_idx;
    ame_pkg::t_idx           r_idx, n_idx;
    logic                    r_wv, n_wv;
    logic                    r_wzero, n_wzero;
    ame_pkg::t_idx           r_widx, n_widx;
    ame_pkg::t_cnt           r_cnt, n_cnt;
    logic                    r_done, n_done;
    logic [ame_pkg::ST_W-1:0] r_status, n_status;
    ame_pkg::t_out           r_row, n_row;

    // Row memory
    ame_pkg::t_row           r_mem [ame_pkg::MAX_VERTICES];
    ame_pkg::t_row           r_rd_data;
    ame_pkg::t_idx           rd_addr;
    logic                    wr_en;
    ame_pkg::t_idx           wr_addr;
    ame_pkg::t_row           wr_data;

    // Shared unit
    ame_pkg::t_col_ctl       col_ctl;
    ame_pkg::t_row           unit_row;
    ame_pkg::t_out           unit_out;
    logic [ame_pkg::OUT_W+ame_pkg::MAX_VERTICES-1:0] unit_wide;

    // Request decode
    ame_pkg::t_cmp           vn_e, sv_e, dv_e, cnt_e;
    ame_pkg::t_cmp           vn_m1, sv_m1, dv_m1, cnt_m1;
    logic                    vn_ok, sv_ok, dv_ok, ins_ok, full;
    logic                    accept, is_ins, present, last_step;

    ame_col_unit u_col_unit (
        .i_row (r_rd_data),
        .i_ctl (col_ctl),
        .o_row (unit_row)
    );

    assign busy               = (r_state != S_IDLE);
    assign accept             = start && !busy;
    assign o_done             = r_done;
    assign o_status           = r_status;
    assign o_row_bits         = r_row;
    assign o_vertex_count_out = cnt_e[ame_pkg::FIELD_W-1:0];

    // Range checks against the current vertex count
    always_comb begin
        vn_e   = ame_pkg::t_cmp'(i_vertex_number);
        sv_e   = ame_pkg::t_cmp'(i_source_vertex);
        dv_e   = ame_pkg::t_cmp'(i_dest_vertex);
        cnt_e  = ame_pkg::t_cmp'(r_cnt);
        vn_m1  = vn_e - ame_pkg::CMP_ONE;
        sv_m1  = sv_e - ame_pkg::CMP_ONE;
        dv_m1  = dv_e - ame_pkg::CMP_ONE;
        cnt_m1 = cnt_e - ame_pkg::CMP_ONE;
        vn_ok  = (vn_e != '0) && (vn_e <= cnt_e);
        sv_ok  = (sv_e != '0) && (sv_e <= cnt_e);
        dv_ok  = (dv_e != '0) && (dv_e <= cnt_e);
        ins_ok = (vn_e != '0) && (vn_e <= cnt_e + ame_pkg::CMP_ONE);
        full   = (cnt_e == ame_pkg::CMP_MAX);
    end

    // Low output columns of the unit result
    always_comb begin
        unit_wide = {{ame_pkg::OUT_W{1'b0}}, unit_row};
        unit_out  = unit_wide[ame_pkg::OUT_W-1:0];
    end

    assign is_ins    = (r_op == ame_pkg::OP_INSERT_VTX);
    assign present   = r_rd_data[r_dv_idx];
    assign last_step = is_ins ? (r_idx == '0) : (r_idx == r_last_idx);

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_p        = r_p;
        n_sv_idx   = r_sv_idx;
        n_dv_idx   = r_dv_idx;
        n_last_idx = r_last_idx;
        n_idx      = r_idx;
        n_wv       = r_wv;
        n_wzero    = r_wzero;
        n_widx     = r_widx;
        n_cnt      = r_cnt;
        n_done     = 1'b0;
        n_status   = r_status;
        n_row      = r_row;
        rd_addr    = sv_m1[ame_pkg::ROW_AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = r_widx;
        wr_data    = r_wzero ? '0 : unit_row;
        col_ctl.op  = is_ins ? ame_pkg::COL_OPEN : ame_pkg::COL_CLOSE;
        col_ctl.col = r_p;

        // write of the row read in the previous cycle of the walk
        if (r_wv) begin
            wr_en = 1'b1;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op       = i_opcode;
                    n_p        = vn_m1[ame_pkg::ROW_AW-1:0];
                    n_sv_idx   = sv_m1[ame_pkg::ROW_AW-1:0];
                    n_dv_idx   = dv_m1[ame_pkg::ROW_AW-1:0];
                    n_last_idx = cnt_m1[ame_pkg::ROW_AW-1:0];
                    n_status   = ame_pkg::ST_OK;
                    n_row      = '0;
                    unique case (i_opcode)
                        ame_pkg::OP_INSERT_VTX: begin
                            if (!ins_ok) begin
                                n_done   = 1'b1;
                                n_status = ame_pkg::ST_RANGE;
                            end else if (full) begin
                                n_done   = 1'b1;
                                n_status = ame_pkg::ST_FULL;
                            end else begin
                                n_idx   = cnt_e[ame_pkg::ROW_AW-1:0];
                                n_state = S_SHIFT;
                            end
                        end
                        ame_pkg::OP_DELETE_VTX: begin
                            if (!vn_ok) begin
                                n_done   = 1'b1;
                                n_status = ame_pkg::ST_RANGE;
                            end else begin
                                n_idx   = '0;
                                n_state = S_SHIFT;
                            end
                        end
                        ame_pkg::OP_ADD_ARC, ame_pkg::OP_DELETE_ARC: begin
                            if (!(sv_ok && dv_ok)) begin
                                n_done   = 1'b1;
                                n_status = ame_pkg::ST_RANGE;
                            end else begin
                                n_state = S_ROW;
                            end
                        end
                        ame_pkg::OP_READ_ROW: begin
                            rd_addr = vn_m1[ame_pkg::ROW_AW-1:0];
                            if (!vn_ok) begin
                                n_done   = 1'b1;
                                n_status = ame_pkg::ST_RANGE;
                            end else begin
                                n_state = S_ROW;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_ROW: begin
                // single row read, optional bit update and write back
                col_ctl.col = r_dv_idx;
                if (r_op == ame_pkg::OP_ADD_ARC) begin
                    col_ctl.op = ame_pkg::COL_SET;
                end else if (r_op == ame_pkg::OP_DELETE_ARC) begin
                    col_ctl.op = ame_pkg::COL_CLEAR;
                end else begin
                    col_ctl.op = ame_pkg::COL_PASS;
                end
                wr_en    = (r_op == ame_pkg::OP_ADD_ARC) || (r_op == ame_pkg::OP_DELETE_ARC);
                wr_addr  = r_sv_idx;
                wr_data  = unit_row;
                n_status = ame_pkg::ST_OK;
                if ((r_op == ame_pkg::OP_ADD_ARC) && present) begin
                    n_status = ame_pkg::ST_PRESENT;
                end else if ((r_op == ame_pkg::OP_DELETE_ARC) && !present) begin
                    n_status = ame_pkg::ST_NOT_FOUND;
                end
                n_row   = unit_out;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_SHIFT: begin
                // insert walks down from the top row, delete walks up
                if (is_ins) begin
                    rd_addr = (r_idx > r_p) ? (r_idx - ame_pkg::IDX_ONE) : r_idx;
                    n_wzero = (r_idx == r_p);
                end else begin
                    rd_addr = (r_idx < r_p) ? r_idx : (r_idx + ame_pkg::IDX_ONE);
                    n_wzero = (r_idx == r_last_idx);
                end
                n_wv   = 1'b1;
                n_widx = r_idx;
                if (last_step) begin
                    n_state = S_FLUSH;
                end else begin
                    n_idx = is_ins ? (r_idx - ame_pkg::IDX_ONE) : (r_idx + ame_pkg::IDX_ONE);
                end
            end
            S_FLUSH: begin
                n_wv     = 1'b0;
                n_done   = 1'b1;
                n_status = ame_pkg::ST_OK;
                n_row    = '0;
                n_cnt    = is_ins ? (r_cnt + ame_pkg::CNT_ONE) : (r_cnt - ame_pkg::CNT_ONE);
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wv    <= 1'b0;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wv    <= n_wv;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_p        <= n_p;
        r_sv_idx   <= n_sv_idx;
        r_dv_idx   <= n_dv_idx;
        r_last_idx <= n_last_idx;
        r_idx      <= n_idx;
        r_wzero    <= n_wzero;
        r_widx     <= n_widx;
        r_status   <= n_status;
        r_row      <= n_row;
    end

    // Row memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

`ifndef NO_ASSERTIONS
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("result shown while sequencer busy");

    a_accept_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_done || busy))
        else $error("accepted request neither answered nor in progress");

    a_wv_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wv |-> ((r_state == S_SHIFT) || (r_state == S_FLUSH)))
        else $error("row write pending outside a vertex walk");

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ame_pkg::t_cmp'(r_cnt) <= ame_pkg::CMP_MAX)
        else $error("vertex count above table size");

    a_widx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wv |-> (ame_pkg::t_cmp'(r_widx) <= ame_pkg::t_cmp'(r_cnt)))
        else $error("walk writes a row beyond the graph");
`endif

endmodule

`default_nettype wire

// ===== dv/adjacency_matrix_editor_tb.sv =====
// Self-checking testbench for the adjacency matrix editor: directed table, then random edits.
`timescale 1ns / 1ps

module adjacency_matrix_editor_tb;
    import ame_pkg::*;

    localparam int RANDOM_ITEMS    = 2000;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = MAX_VERTICES + 8;
    localparam int REPORT_LIMIT    = 10;
    localparam int DIRECTED_ROWS   = 24;

    // Opcodes the block leaves undefined
    localparam logic [OP_W-1:0] OP_FIRST_SPARE = 3'd5;
    localparam logic [OP_W-1:0] OP_LAST_SPARE  = 3'd7;

    typedef struct packed {
        logic [ST_W-1:0]    status;
        t_out               row_bits;
        logic [FIELD_W-1:0] vertex_count;
    } t_graph_answer;

    // One row of the directed plan; pinned rows carry a hand-written answer
    typedef struct {
        logic [OP_W-1:0]    op;
        logic [FIELD_W-1:0] vn;
        logic [FIELD_W-1:0] sv;
        logic [FIELD_W-1:0] dv;
        int                 reps;
        bit                 pinned;
        logic [ST_W-1:0]    pin_status;
        t_out               pin_row;
        logic [FIELD_W-1:0] pin_count;
    } t_plan_row;

    logic                 i_clk;
    logic                 i_rst_n         = 1'b0;
    logic                 start           = 1'b0;
    logic [OP_W-1:0]      i_opcode        = '0;
    logic [FIELD_W-1:0]   i_vertex_number = '0;
    logic [FIELD_W-1:0]   i_source_vertex = '0;
    logic [FIELD_W-1:0]   i_dest_vertex   = '0;
    wire                  busy;
    wire                  o_done;
    wire  [ST_W-1:0]      o_status;
    wire  [OUT_W-1:0]     o_row_bits;
    wire  [FIELD_W-1:0]   o_vertex_count_out;

    // Shadow copy of the graph
    t_row shadow_rows [MAX_VERTICES];
    int   shadow_count = 0;
    int   largest_graph = 0;

    t_graph_answer expected_answers [$];

    int mismatches     = 0;
    int unexpected     = 0;
    int reported       = 0;
    int results_seen   = 0;
    int quiet_cycles   = 0;
    int burst_left     = 0;
    int op_counts      [8];
    int status_counts  [8];

    t_plan_row directed_plan [DIRECTED_ROWS] = '{
        // empty graph: everything but insert is out of range
        '{OP_READ_ROW,    6'd1,  6'd0,  6'd0,  1, 1'b1, ST_RANGE,   32'h0, 6'd0},
        '{OP_ADD_ARC,     6'd0,  6'd1,  6'd1,  1, 1'b1, ST_RANGE,   32'h0, 6'd0},
        '{OP_DELETE_ARC,  6'd0,  6'd63, 6'd63, 1, 1'b1, ST_RANGE,   32'h0, 6'd0},
        '{OP_DELETE_VTX,  6'd1,  6'd0,  6'd0,  1, 1'b1, ST_RANGE,   32'h0, 6'd0},
        '{OP_INSERT_VTX,  6'd0,  6'd0,  6'd0,  1, 1'b1, ST_RANGE,   32'h0, 6'd0},
        '{OP_INSERT_VTX,  6'd2,  6'd0,  6'd0,  1, 1'b1, ST_RANGE,   32'h0, 6'd0},
        '{OP_INSERT_VTX,  6'd1,  6'd0,  6'd0,  1, 1'b1, ST_OK,      32'h0, 6'd1},
        // undefined opcodes answer ok and change nothing
        '{OP_FIRST_SPARE, 6'd63, 6'd63, 6'd63, 1, 1'b1, ST_OK,      32'h0, 6'd1},
        '{OP_LAST_SPARE,  6'd0,  6'd0,  6'd0,  1, 1'b1, ST_OK,      32'h0, 6'd1},
        '{OP_ADD_ARC,     6'd0,  6'd1,  6'd1,  1, 1'b1, ST_OK,      32'h1, 6'd1},
        '{OP_ADD_ARC,     6'd0,  6'd1,  6'd1,  1, 1'b1, ST_PRESENT, 32'h1, 6'd1},
        '{OP_ADD_ARC,     6'd0,  6'd1,  6'd2,  1, 1'b1, ST_RANGE,   32'h0, 6'd1},
        '{OP_DELETE_ARC,  6'd0,  6'd1,  6'd0,  1, 1'b1, ST_RANGE,   32'h0, 6'd1},
        '{OP_INSERT_VTX,  6'd1,  6'd0,  6'd0,  1, 1'b1, ST_OK,      32'h0, 6'd2},
        // self loop moved to vertex 2 by the insert above
        '{OP_ADD_ARC,     6'd0,  6'd1,  6'd2,  1, 1'b0, ST_OK,      32'h0, 6'd0},
        '{OP_DELETE_ARC,  6'd0,  6'd2,  6'd1,  1, 1'b0, ST_OK,      32'h0, 6'd0},
        '{OP_DELETE_ARC,  6'd0,  6'd2,  6'd2,  1, 1'b0, ST_OK,      32'h0, 6'd0},
        '{OP_INSERT_VTX,  6'd3,  6'd0,  6'd0,  1, 1'b0, ST_OK,      32'h0, 6'd0},
        '{OP_DELETE_VTX,  6'd1,  6'd0,  6'd0,  1, 1'b0, ST_OK,      32'h0, 6'd0},
        // fill the table, last one runs into the full case
        '{OP_INSERT_VTX,  6'd1,  6'd0,  6'd0,  MAX_VERTICES - 1, 1'b0, ST_OK, 32'h0, 6'd0},
        '{OP_INSERT_VTX,  6'(MAX_VERTICES + 1), 6'd0, 6'd0, 1, 1'b1, ST_FULL, 32'h0,
          6'(MAX_VERTICES)},
        '{OP_INSERT_VTX,  6'(MAX_VERTICES + 2), 6'd0, 6'd0, 1, 1'b1, ST_RANGE, 32'h0,
          6'(MAX_VERTICES)},
        '{OP_ADD_ARC,     6'd0,  6'(MAX_VERTICES), 6'(MAX_VERTICES), 1, 1'b0, ST_OK, 32'h0, 6'd0},
        '{OP_DELETE_VTX,  6'(MAX_VERTICES), 6'd0, 6'd0, 1, 1'b0, ST_OK, 32'h0, 6'd0}
    };

    adjacency_matrix_editor uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_opcode           (i_opcode),
        .i_vertex_number    (i_vertex_number),
        .i_source_vertex    (i_source_vertex),
        .i_dest_vertex      (i_dest_vertex),
        .o_done             (o_done),
        .o_status           (o_status),
        .o_row_bits         (o_row_bits),
        .o_vertex_count_out (o_vertex_count_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Apply one request to the shadow graph and return the answer it gives
    function automatic t_graph_answer apply_graph_edit(input logic [OP_W-1:0] op,
                                                       input logic [FIELD_W-1:0] vn,
                                                       input logic [FIELD_W-1:0] sv,
                                                       input logic [FIELD_W-1:0] dv);
        t_graph_answer ans;
        int   v;
        int   s;
        int   d;
        int   n;
        int   i;
        t_row mask;
        t_row tmp;
        v = int'(vn);
        s = int'(sv);
        d = int'(dv);
        n = shadow_count;
        ans.status   = ST_OK;
        ans.row_bits = '0;
        case (op)
            OP_INSERT_VTX: begin
                if (v < 1 || v > n + 1) begin
                    ans.status = ST_RANGE;
                end else if (n >= MAX_VERTICES) begin
                    ans.status = ST_FULL;
                end else begin
                    // open column v-1 in every used row, then shift rows up
                    mask = (t_row'(1) << (v - 1)) - t_row'(1);
                    for (i = 0; i < n; i++) begin
                        tmp = shadow_rows[i];
                        shadow_rows[i] = (tmp & mask) | ((tmp & ~mask) << 1);
                    end
                    for (i = n; i >= v; i--)
                        shadow_rows[i] = shadow_rows[i-1];
                    shadow_rows[v-1] = '0;
                    shadow_count++;
                end
            end
            OP_ADD_ARC, OP_DELETE_ARC: begin
                if (s < 1 || s > n || d < 1 || d > n) begin
                    ans.status = ST_RANGE;
                end else begin
                    if (op == OP_ADD_ARC) begin
                        if (shadow_rows[s-1][d-1])
                            ans.status = ST_PRESENT;
                        else
                            shadow_rows[s-1][d-1] = 1'b1;
                    end else begin
                        if (shadow_rows[s-1][d-1])
                            shadow_rows[s-1][d-1] = 1'b0;
                        else
                            ans.status = ST_NOT_FOUND;
                    end
                    ans.row_bits = t_out'(shadow_rows[s-1]);
                end
            end
            OP_DELETE_VTX: begin
                if (v < 1 || v > n) begin
                    ans.status = ST_RANGE;
                end else begin
                    // drop row v-1, then close column v-1 in the remaining rows
                    for (i = v - 1; i + 1 < n; i++)
                        shadow_rows[i] = shadow_rows[i+1];
                    shadow_rows[n-1] = '0;
                    shadow_count--;
                    mask = (t_row'(1) << (v - 1)) - t_row'(1);
                    for (i = 0; i < shadow_count; i++) begin
                        tmp = shadow_rows[i];
                        shadow_rows[i] = (tmp & mask) | ((tmp >> v) << (v - 1));
                    end
                end
            end
            OP_READ_ROW: begin
                if (v < 1 || v > n)
                    ans.status = ST_RANGE;
                else
                    ans.row_bits = t_out'(shadow_rows[v-1]);
            end
            default: begin
            end
        endcase
        ans.vertex_count = FIELD_W'(shadow_count);
        if (shadow_count > largest_graph)
            largest_graph = shadow_count;
        return ans;
    endfunction

    // Mostly a valid one-based vertex, sometimes zero, just past the end, the top code or any code
    function automatic logic [FIELD_W-1:0] pick_vertex(input int hi);
        if (hi >= 1 && $urandom_range(0, 99) < 90)
            return FIELD_W'($urandom_range(1, hi));
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return FIELD_W'(hi + 1);
            2:       return '1;
            default: return FIELD_W'($urandom_range(0, 63));
        endcase
    endfunction

    // Present one request, wait for its transfer, record the answer, then sometimes idle a while
    task automatic issue_request(input logic [OP_W-1:0] op, input logic [FIELD_W-1:0] vn,
                                 input logic [FIELD_W-1:0] sv, input logic [FIELD_W-1:0] dv,
                                 input bit pinned, input t_graph_answer pinned_answer);
        t_graph_answer predicted;
        int gap;
        int roll;
        i_opcode        <= op;
        i_vertex_number <= vn;
        i_source_vertex <= sv;
        i_dest_vertex   <= dv;
        start           <= 1'b1;
        do
            @(posedge i_clk);
        while (busy);
        predicted = apply_graph_edit(op, vn, sv, dv);
        expected_answers.push_back(pinned ? pinned_answer : predicted);
        op_counts[op]++;
        // idle gap: bursts with none, mostly short, a few long
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
                burst_left = $urandom_range(20, 60);
                gap = 0;
            end else if (roll < 40) begin
                gap = 0;
            end else if (roll < 85) begin
                gap = $urandom_range(1, 3);
            end else if (roll < 96) begin
                gap = $urandom_range(4, 12);
            end else begin
                gap = $urandom_range(20, 60);
            end
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Result checker: every strobed result against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_graph_answer want;
        if (i_rst_n && o_done === 1'b1) begin
            results_seen++;
            if (!$isunknown(o_status))
                status_counts[o_status]++;
            if (expected_answers.size() == 0) begin
                unexpected++;
                if (reported < REPORT_LIMIT) begin
                    reported++;
                    $display("[%0t] result with nothing pending: status %0d row %h count %0d",
                             $time, o_status, o_row_bits, o_vertex_count_out);
                end
            end else begin
                want = expected_answers.pop_front();
                if (o_status !== want.status || o_row_bits !== want.row_bits ||
                    o_vertex_count_out !== want.vertex_count) begin
                    mismatches++;
                    if (reported < REPORT_LIMIT) begin
                        reported++;
                        $display("[%0t] mismatch: status %0d/%0d row %h/%h count %0d/%0d",
                                 $time, o_status, want.status, o_row_bits, want.row_bits,
                                 o_vertex_count_out, want.vertex_count);
                        $display("        (actual/expected)");
                    end
                end
            end
        end
    end

    // Watchdog: cycles with neither a request nor a result transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done === 1'b1)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results still pending",
                     quiet_cycles, expected_answers.size());
            $display("** adjacency_matrix_editor: FAILED **");
            $finish;
        end
    end

    initial begin : stimulus
        int                 row_idx;
        int                 rep;
        int                 item_idx;
        int                 target_size;
        int                 roll;
        int                 n;
        int                 leftover;
        logic [OP_W-1:0]    op;
        logic [FIELD_W-1:0] vn;
        logic [FIELD_W-1:0] sv;
        logic [FIELD_W-1:0] dv;
        t_graph_answer      pin;

        for (row_idx = 0; row_idx < MAX_VERTICES; row_idx++)
            shadow_rows[row_idx] = '0;
        for (row_idx = 0; row_idx < 8; row_idx++) begin
            op_counts[row_idx]     = 0;
            status_counts[row_idx] = 0;
        end
        target_size = 1;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        for (row_idx = 0; row_idx < DIRECTED_ROWS; row_idx++) begin
            pin.status       = directed_plan[row_idx].pin_status;
            pin.row_bits     = directed_plan[row_idx].pin_row;
            pin.vertex_count = directed_plan[row_idx].pin_count;
            for (rep = 0; rep < directed_plan[row_idx].reps; rep++)
                issue_request(directed_plan[row_idx].op, directed_plan[row_idx].vn,
                              directed_plan[row_idx].sv, directed_plan[row_idx].dv,
                              directed_plan[row_idx].pinned, pin);
        end

        // Random edits, steering the graph size between a few targets
        for (item_idx = 0; item_idx < RANDOM_ITEMS; item_idx++) begin
            if (item_idx % 150 == 0) begin
                case ($urandom_range(0, 3))
                    0:       target_size = 1;
                    1:       target_size = 6;
                    2:       target_size = 18;
                    default: target_size = MAX_VERTICES;
                endcase
            end
            n    = shadow_count;
            roll = $urandom_range(0, 99);
            vn   = FIELD_W'($urandom_range(0, 63));
            sv   = FIELD_W'($urandom_range(0, 63));
            dv   = FIELD_W'($urandom_range(0, 63));
            if (roll < 6) begin
                op = OP_W'($urandom_range(OP_FIRST_SPARE, OP_LAST_SPARE));
            end else if (roll < 28) begin
                if (n < target_size || (n == MAX_VERTICES && $urandom_range(0, 1))) begin
                    op = OP_INSERT_VTX;
                    vn = pick_vertex(n + 1);
                end else begin
                    op = OP_DELETE_VTX;
                    vn = pick_vertex(n);
                end
            end else if (roll < 58) begin
                op = OP_ADD_ARC;
                sv = pick_vertex(n);
                dv = pick_vertex(n);
            end else if (roll < 78) begin
                op = OP_DELETE_ARC;
                sv = pick_vertex(n);
                dv = pick_vertex(n);
            end else begin
                op = OP_READ_ROW;
                vn = pick_vertex(n);
            end
            issue_request(op, vn, sv, dv, 1'b0, '0);
        end
        start <= 1'b0;

        // Drain, then let any stray result show up
        while (expected_answers.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        leftover = expected_answers.size();
        $display("Checked %0d results: %0d inserts, %0d vertex deletes, %0d arc adds, %0d %s",
                 results_seen, op_counts[OP_INSERT_VTX], op_counts[OP_DELETE_VTX],
                 op_counts[OP_ADD_ARC], op_counts[OP_DELETE_ARC], "arc deletes");
        $display("Reads %0d, spare opcodes %0d; %s %0d/%0d/%0d/%0d/%0d, largest graph %0d",
                 op_counts[OP_READ_ROW],
                 op_counts[OP_FIRST_SPARE] + op_counts[OP_FIRST_SPARE + 3'd1] +
                 op_counts[OP_LAST_SPARE],
                 "status ok/present/missing/range/full",
                 status_counts[ST_OK], status_counts[ST_PRESENT], status_counts[ST_NOT_FOUND],
                 status_counts[ST_RANGE], status_counts[ST_FULL], largest_graph);
        if (mismatches == 0 && unexpected == 0 && leftover == 0) begin
            $display("** adjacency_matrix_editor: PASSED **");
        end else begin
            $display("mismatches %0d, unexpected results %0d, missing results %0d",
                     mismatches, unexpected, leftover);
            $display("** adjacency_matrix_editor: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ame_pkg.sv
rtl/ame_col_unit.sv
rtl/adjacency_matrix_editor.sv
dv/adjacency_matrix_editor_tb.sv
